// ----- rtl/scs_pkg.sv -----
`default_nettype none

package scs_pkg;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic str_lit;
		logic chr_lit;
		logic line_cmt;
		logic block_cmt;
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  emit;
		logic  swallow;
	} decision_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       text_done;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [1:0] num;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic decision_t decide(
		input logic [7:0] c,
		input logic [7:0] n,
		input logic       after_bs,
		input mode_t      m
	);
		decision_t d;
		logic      cmt;
		d.mode    = m;
		d.emit    = 1'b0;
		d.swallow = 1'b0;
		cmt       = m.line_cmt | m.block_cmt;
		if (c == CH_DQUOTE && !m.chr_lit && !cmt) begin
			if (!after_bs)
				d.mode.str_lit = ~m.str_lit;
			d.emit = 1'b1;
		end else if (c == CH_SQUOTE && !m.str_lit && !cmt) begin
			if (!after_bs)
				d.mode.chr_lit = ~m.chr_lit;
			d.emit = 1'b1;
		end else if (m.str_lit || m.chr_lit) begin
			d.emit = 1'b1;
		end else if (c == CH_SLASH && n == CH_SLASH && !m.block_cmt) begin
			d.mode.line_cmt = 1'b1;
			d.swallow       = 1'b1;
		end else if (c == CH_SLASH && n == CH_STAR && !m.line_cmt) begin
			d.mode.block_cmt = 1'b1;
			d.swallow        = 1'b1;
		end else if (c == CH_STAR && n == CH_SLASH && m.block_cmt) begin
			d.mode.block_cmt = 1'b0;
			d.swallow        = 1'b1;
		end else if (c == CH_NL) begin
			d.mode.line_cmt = 1'b0;
			d.emit          = 1'b1;
		end else begin
			d.emit = ~cmt;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/scs_core.sv -----
`default_nettype none

module scs_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire logic [7:0]     text_byte,
	input  wire logic           end_of_text,
	output scs_pkg::push_t      push
);

	logic [7:0]         held_byte_q;
	logic               held_valid_q;
	logic               held_after_bs_q;
	logic               prev_bs_q;
	scs_pkg::mode_t     mode_q;

	scs_pkg::decision_t d1;
	scs_pkg::decision_t d2;
	logic               e1;
	logic               e2;
	scs_pkg::mode_t     mode_a;
	logic [7:0]         held_a;
	logic               hv_a;
	logic               hab_a;
	scs_pkg::result_t   r_first;
	scs_pkg::result_t   r_second;
	logic [1:0]         num;

	always_comb begin
		d1     = scs_pkg::decide(held_byte_q, text_byte, held_after_bs_q, mode_q);
		e1     = held_valid_q & d1.emit;
		mode_a = held_valid_q ? d1.mode : mode_q;
		if (held_valid_q && d1.swallow) begin
			hv_a   = 1'b0;
			held_a = held_byte_q;
			hab_a  = held_after_bs_q;
		end else begin
			hv_a   = 1'b1;
			held_a = text_byte;
			hab_a  = prev_bs_q;
		end
		// end of text: decide the remaining held byte against a zero lookahead
		d2 = scs_pkg::decide(held_a, scs_pkg::CH_NUL, hab_a, mode_a);
		e2 = end_of_text & hv_a & d2.emit;

		r_first  = '{out_byte: held_byte_q, byte_valid: 1'b1, text_done: 1'b0,
			run_last: 1'b1};
		r_second = '{out_byte: held_a, byte_valid: 1'b1, text_done: 1'b1,
			run_last: 1'b1};
		num      = {1'b0, e1};
		if (end_of_text) begin
			if (e1 && e2) begin
				r_first.run_last = 1'b0;
				num              = 2'd2;
			end else if (e1) begin
				r_first.text_done = 1'b1;
				num               = 2'd1;
			end else if (e2) begin
				r_first = r_second;
				num     = 2'd1;
			end else begin
				r_first = '{out_byte: scs_pkg::CH_NUL, byte_valid: 1'b0,
					text_done: 1'b1, run_last: 1'b1};
				num     = 2'd1;
			end
		end

		push.num    = advance ? num : 2'd0;
		push.first  = r_first;
		push.second = r_second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q     <= '0;
			held_valid_q    <= 1'b0;
			held_after_bs_q <= 1'b0;
			prev_bs_q       <= 1'b0;
			mode_q          <= '0;
		end else if (advance) begin
			if (end_of_text) begin
				held_byte_q     <= '0;
				held_valid_q    <= 1'b0;
				held_after_bs_q <= 1'b0;
				prev_bs_q       <= 1'b0;
				mode_q          <= '0;
			end else begin
				held_byte_q     <= held_a;
				held_valid_q    <= hv_a;
				held_after_bs_q <= hab_a;
				prev_bs_q       <= (text_byte == scs_pkg::CH_BSLASH);
				mode_q          <= mode_a;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/scs_out_queue.sv -----
`default_nettype none

module scs_out_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire scs_pkg::push_t push,
	output logic               room,
	output logic               result_valid,
	input  wire logic          result_stall,
	output scs_pkg::result_t   head
);

	scs_pkg::result_t                 entry_q [scs_pkg::OQ_DEPTH];
	logic [scs_pkg::OQ_PTR_W-1:0]     wr_ptr_q;
	logic [scs_pkg::OQ_PTR_W-1:0]     rd_ptr_q;
	logic [scs_pkg::OQ_CNT_W-1:0]     count_q;
	logic                             pop;

	assign result_valid = (count_q != '0);
	assign pop          = result_valid & ~result_stall;
	assign head         = entry_q[rd_ptr_q];
	// space for the two results an item may cause
	assign room = (count_q <= scs_pkg::OQ_CNT_W'(scs_pkg::OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0)
			entry_q[wr_ptr_q] <= push.first;
		if (push.num == 2'd2)
			entry_q[wr_ptr_q + scs_pkg::OQ_PTR_W'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + scs_pkg::OQ_PTR_W'(push.num);
			if (pop)
				rd_ptr_q <= rd_ptr_q + scs_pkg::OQ_PTR_W'(1);
			count_q <= count_q + scs_pkg::OQ_CNT_W'(push.num)
				- scs_pkg::OQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/source_comment_stripper.sv -----
`default_nettype none

// Strips line and block comments from a byte stream while passing string and
// character literals through. One byte is accepted per cycle while text_stall
// is low; bytes pass an input register, then decision logic into a four-entry
// result queue. Each byte causes zero or one result, and an end-of-text byte
// one or two, so the sustained rate is one byte per cycle while result_stall
// is low, set by the one-result-per-cycle output port. Each byte is decided
// when the next one arrives, so a kept byte appears one transaction late; the
// end-of-text transaction flushes it, marks text_done and clears all state.

module source_comment_stripper (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       text_valid,
	output logic            text_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            text_done,
	output logic            run_last
);

	logic               s1_valid_q;
	logic [7:0]         text_byte_s1;
	logic               end_of_text_s1;
	logic               room;
	logic               advance;
	scs_pkg::push_t     push;
	scs_pkg::result_t   head;

	assign advance    = s1_valid_q & room;
	assign text_stall = s1_valid_q & ~room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (!text_stall)
			s1_valid_q <= text_valid;
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			text_byte_s1   <= text_byte;
			end_of_text_s1 <= end_of_text;
		end
	end

	scs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.text_byte   (text_byte_s1),
		.end_of_text (end_of_text_s1),
		.push        (push)
	);

	scs_out_queue u_out_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head)
	);

	assign out_byte   = head.out_byte;
	assign byte_valid = head.byte_valid;
	assign text_done  = head.text_done;
	assign run_last   = head.run_last;

endmodule

`default_nettype wire
